FILE: sv/oac_pkg.sv
// ----------------------------------------------------------------------------
// oac_pkg
// Shared types, codes and reset values of the obstacle avoidance controller.
// ----------------------------------------------------------------------------
package oac_pkg;

    // drive action codes
    typedef enum logic [2:0] {
        DRV_STOP     = 3'd0,
        DRV_STRAIGHT = 3'd1,
        DRV_REVERSE  = 3'd2,
        DRV_RIGHT    = 3'd3,
        DRV_LEFT     = 3'd4
    } t_drive;

    // last turn codes
    typedef enum logic [1:0] {
        LAST_NONE  = 2'd0,
        LAST_RIGHT = 2'd1,
        LAST_LEFT  = 2'd2
    } t_turn;

    // configuration register indexes
    localparam logic [2:0] CFG_OBSTACLE_THRESHOLD = 3'd0;
    localparam logic [2:0] CFG_REAR_THRESHOLD     = 3'd1;
    localparam logic [2:0] CFG_REVERSE_TICKS      = 3'd2;
    localparam logic [2:0] CFG_TURN_START         = 3'd3;
    localparam logic [2:0] CFG_ESCAPE_TICKS       = 3'd4;
    localparam logic [2:0] CFG_OSCILLATION_LIMIT  = 3'd5;

    // configuration reset values
    localparam logic [7:0] RST_OBSTACLE_THRESHOLD = 8'd75;
    localparam logic [7:0] RST_REAR_THRESHOLD     = 8'd110;
    localparam logic [7:0] RST_REVERSE_TICKS      = 8'd69;
    localparam logic [7:0] RST_TURN_START         = 8'd30;
    localparam logic [7:0] RST_ESCAPE_TICKS       = 8'd50;
    localparam logic [7:0] RST_OSCILLATION_LIMIT  = 8'd10;

    // h-bridge pin patterns
    localparam logic [3:0] BRIDGE_FORWARD = 4'h9;
    localparam logic [3:0] BRIDGE_LEFT    = 4'hA;
    localparam logic [3:0] BRIDGE_REVERSE = 4'h6;
    localparam logic [3:0] BRIDGE_OFF     = 4'h0;

    // configuration set
    typedef struct packed {
        logic [7:0] obstacle_threshold;
        logic [7:0] rear_threshold;
        logic [7:0] reverse_ticks;
        logic [7:0] turn_start;
        logic [7:0] escape_ticks;
        logic [7:0] oscillation_limit;
    } t_cfg;

    // state kept between ticks
    typedef struct packed {
        logic [7:0] reverse_count;
        logic [7:0] escape_count;
        logic [7:0] alternation_count;
        t_turn      previous_turn;
        t_drive     current_drive;
    } t_state;

    // bridge pin pattern for a drive code
    function automatic logic [3:0] bridge_of(input t_drive drive);
        logic [3:0] bits;
        unique case (drive)
            DRV_STRAIGHT: bits = BRIDGE_FORWARD;
            DRV_RIGHT:    bits = BRIDGE_FORWARD;
            DRV_LEFT:     bits = BRIDGE_LEFT;
            DRV_REVERSE:  bits = BRIDGE_REVERSE;
            default:      bits = BRIDGE_OFF;
        endcase
        return bits;
    endfunction

endpackage

FILE: sv/oac_decide.sv
// ----------------------------------------------------------------------------
// oac_decide
// Decision logic for one control tick: next state from the current state,
// the four range readings and the configuration.
// ----------------------------------------------------------------------------
module oac_decide (
    input  oac_pkg::t_state i_state,
    input  oac_pkg::t_cfg   i_cfg,
    input  logic [7:0]      i_left_range,
    input  logic [7:0]      i_right_range,
    input  logic [7:0]      i_front_range,
    input  logic [7:0]      i_back_range,
    output oac_pkg::t_state o_state
);
    import oac_pkg::*;

    logic       left_blocked;
    logic       right_blocked;
    logic       front_blocked;
    logic       alt_right;
    logic       alt_left;
    logic [7:0] alt_count_right;
    logic [7:0] alt_count_left;
    logic [7:0] reload_count;

    // obstacle flags
    assign left_blocked  = i_left_range  > i_cfg.obstacle_threshold;
    assign right_blocked = i_right_range > i_cfg.obstacle_threshold;
    assign front_blocked = i_front_range > i_cfg.obstacle_threshold;

    // oscillation counter candidates for a right or a left turn
    assign alt_right       = (i_state.previous_turn | LAST_RIGHT) == 2'd3;
    assign alt_left        = (i_state.previous_turn | LAST_LEFT) == 2'd3;
    assign alt_count_right = alt_right ? i_state.alternation_count + 8'd1 : 8'd0;
    assign alt_count_left  = alt_left  ? i_state.alternation_count + 8'd1 : 8'd0;

    // rear obstacle reload, floored at zero
    assign reload_count = (i_cfg.turn_start >= 8'd2) ? i_cfg.turn_start - 8'd2 : 8'd0;

    // priority decision
    always_comb begin
        o_state = i_state;
        priority if (i_state.reverse_count != 8'd0) begin
            if (i_back_range > i_cfg.rear_threshold) begin
                o_state.reverse_count = reload_count;
            end else begin
                if (i_state.reverse_count < i_cfg.turn_start) begin
                    o_state.current_drive = DRV_RIGHT;
                end
                o_state.reverse_count = i_state.reverse_count - 8'd1;
            end
        end else if (i_state.escape_count != 8'd0) begin
            o_state.current_drive = DRV_LEFT;
            o_state.escape_count  = i_state.escape_count - 8'd1;
        end else if (front_blocked && left_blocked && right_blocked) begin
            o_state.current_drive = DRV_REVERSE;
            o_state.reverse_count = i_cfg.reverse_ticks;
            o_state.previous_turn = LAST_NONE;
        end else if (left_blocked) begin
            o_state.alternation_count = alt_count_right;
            if (alt_count_right > i_cfg.oscillation_limit) begin
                o_state.escape_count = i_cfg.escape_ticks;
            end
            o_state.current_drive = DRV_RIGHT;
            o_state.previous_turn = LAST_RIGHT;
        end else if (right_blocked) begin
            o_state.alternation_count = alt_count_left;
            if (alt_count_left > i_cfg.oscillation_limit) begin
                o_state.escape_count = i_cfg.escape_ticks;
            end
            o_state.current_drive = DRV_LEFT;
            o_state.previous_turn = LAST_LEFT;
        end else if (front_blocked) begin
            o_state.current_drive = DRV_REVERSE;
            o_state.reverse_count = i_cfg.reverse_ticks;
            o_state.previous_turn = LAST_NONE;
        end else begin
            o_state.current_drive = DRV_STRAIGHT;
            o_state.previous_turn = LAST_NONE;
        end
    end

endmodule

FILE: sv/obstacle_avoidance_controller_core.sv
// ----------------------------------------------------------------------------
// obstacle_avoidance_controller_core
// Picks a drive action per control tick from four range readings.
// ----------------------------------------------------------------------------
// output: an accepted tick's result is in the output register in the next cycle
// throughput: one tick per cycle unless stalled; the state update is a single
//   compare and counter step from the state registers back to themselves
// reset: synchronous, active low; clears the state and the output valid and
//   loads the configuration registers with their default values
module obstacle_avoidance_controller_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // tick input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_left_range,
    input  logic [7:0] i_right_range,
    input  logic [7:0] i_front_range,
    input  logic [7:0] i_back_range,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_drive_mode,
    output logic [3:0] o_bridge_bits,
    output logic [1:0] o_turn_memory,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import oac_pkg::*;

    t_cfg       r_cfg;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    logic [2:0] r_drive_mode;
    logic [3:0] r_bridge_bits;
    logic [1:0] r_turn_memory;
    logic       in_take;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_take     = i_in_valid && o_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.obstacle_threshold <= RST_OBSTACLE_THRESHOLD;
            r_cfg.rear_threshold     <= RST_REAR_THRESHOLD;
            r_cfg.reverse_ticks      <= RST_REVERSE_TICKS;
            r_cfg.turn_start         <= RST_TURN_START;
            r_cfg.escape_ticks       <= RST_ESCAPE_TICKS;
            r_cfg.oscillation_limit  <= RST_OSCILLATION_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OBSTACLE_THRESHOLD: r_cfg.obstacle_threshold <= i_cfg_data;
                CFG_REAR_THRESHOLD:     r_cfg.rear_threshold     <= i_cfg_data;
                CFG_REVERSE_TICKS:      r_cfg.reverse_ticks      <= i_cfg_data;
                CFG_TURN_START:         r_cfg.turn_start         <= i_cfg_data;
                CFG_ESCAPE_TICKS:       r_cfg.escape_ticks       <= i_cfg_data;
                CFG_OSCILLATION_LIMIT:  r_cfg.oscillation_limit  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // tick decision
    oac_decide u_decide (
        .i_state       (r_state),
        .i_cfg         (r_cfg),
        .i_left_range  (i_left_range),
        .i_right_range (i_right_range),
        .i_front_range (i_front_range),
        .i_back_range  (i_back_range),
        .o_state       (n_state)
    );

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.reverse_count     <= 8'd0;
            r_state.escape_count      <= 8'd0;
            r_state.alternation_count <= 8'd0;
            r_state.previous_turn     <= LAST_NONE;
            r_state.current_drive     <= DRV_STOP;
        end else if (in_take) begin
            r_state <= n_state;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_drive_mode  <= n_state.current_drive;
            r_bridge_bits <= bridge_of(n_state.current_drive);
            r_turn_memory <= n_state.previous_turn;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_mode  = r_drive_mode;
    assign o_bridge_bits = r_bridge_bits;
    assign o_turn_memory = r_turn_memory;

endmodule

FILE: dv/tb_obstacle_avoidance_controller_core.sv
// ----------------------------------------------------------------------------
// tb_obstacle_avoidance_controller_core
// Self-checking bench for the obstacle avoidance controller. Control ticks
// are queued by a stimulus process, driven by a valid/ready driver and
// checked by a monitor against an in-bench model of the drive decisions,
// across several configuration sets, random idling and a long output stall.
// ----------------------------------------------------------------------------
module tb_obstacle_avoidance_controller_core;
    import oac_pkg::*;

    localparam int WATCHDOG_CYCLES = 1000;
    localparam int HOLD_CYCLES     = 60;

    typedef struct {
        logic [7:0] left_r;
        logic [7:0] right_r;
        logic [7:0] front_r;
        logic [7:0] back_r;
    } t_tick;

    typedef struct {
        t_drive     drive;
        logic [3:0] bridge;
        t_turn      turn;
    } t_action;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_left_range;
    logic [7:0] i_right_range;
    logic [7:0] i_front_range;
    logic [7:0] i_back_range;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [2:0] o_drive_mode;
    logic [3:0] o_bridge_bits;
    logic [1:0] o_turn_memory;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    obstacle_avoidance_controller_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_left_range  (i_left_range),
        .i_right_range (i_right_range),
        .i_front_range (i_front_range),
        .i_back_range  (i_back_range),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_drive_mode  (o_drive_mode),
        .o_bridge_bits (o_bridge_bits),
        .o_turn_memory (o_turn_memory),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // bench copy of the configuration
    logic [7:0] thr_obstacle = RST_OBSTACLE_THRESHOLD;
    logic [7:0] thr_rear     = RST_REAR_THRESHOLD;
    logic [7:0] rev_load     = RST_REVERSE_TICKS;
    logic [7:0] turn_below   = RST_TURN_START;
    logic [7:0] escape_load  = RST_ESCAPE_TICKS;
    logic [7:0] swing_limit  = RST_OSCILLATION_LIMIT;

    // bench copy of the controller state
    logic [7:0] rev_left    = 8'd0;
    logic [7:0] escape_left = 8'd0;
    logic [7:0] swing_count = 8'd0;
    t_turn      last_turn   = LAST_NONE;
    t_drive     drive_now   = DRV_STOP;

    t_tick   pending_ticks[$];
    t_action expected_actions[$];
    int      ticks_queued    = 0;
    int      results_seen    = 0;
    int      error_count     = 0;
    bit      tick_taken      = 1'b0;
    bit      quiet_stretch   = 1'b0;
    bit      hold_req        = 1'b0;
    bit      hold_off        = 1'b0;
    bit      left_block_next = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // h-bridge pins for a drive action
    function automatic logic [3:0] bridge_pattern(input t_drive drive);
        case (drive)
            DRV_STRAIGHT, DRV_RIGHT: return BRIDGE_FORWARD;
            DRV_LEFT:                return BRIDGE_LEFT;
            DRV_REVERSE:             return BRIDGE_REVERSE;
            default:                 return BRIDGE_OFF;
        endcase
    endfunction

    // alternating side turns build up the oscillation count
    function automatic void count_turn(input t_turn turn);
        if (last_turn != LAST_NONE && last_turn != turn)
            swing_count = swing_count + 8'd1;
        else
            swing_count = 8'd0;
        if (swing_count > swing_limit)
            escape_left = escape_load;
    endfunction

    function automatic void begin_reverse();
        drive_now = DRV_REVERSE;
        rev_left  = rev_load;
        last_turn = LAST_NONE;
    endfunction

    // drive decision for one tick, advancing the bench state
    function automatic t_action predict_action(input logic [7:0] left_r, right_r,
                                               front_r, back_r);
        t_action act;
        logic    lb;
        logic    rb;
        logic    fb;
        lb = left_r > thr_obstacle;
        rb = right_r > thr_obstacle;
        fb = front_r > thr_obstacle;
        if (rev_left != 8'd0) begin
            // rear obstacle restarts the manoeuvre just under the turn point
            if (back_r > thr_rear) begin
                rev_left = (turn_below >= 8'd2) ? turn_below - 8'd2 : 8'd0;
            end else begin
                if (rev_left < turn_below)
                    drive_now = DRV_RIGHT;
                rev_left = rev_left - 8'd1;
            end
        end else if (escape_left != 8'd0) begin
            drive_now   = DRV_LEFT;
            escape_left = escape_left - 8'd1;
        end else if (fb && lb && rb) begin
            begin_reverse();
        end else if (lb) begin
            count_turn(LAST_RIGHT);
            drive_now = DRV_RIGHT;
            last_turn = LAST_RIGHT;
        end else if (rb) begin
            count_turn(LAST_LEFT);
            drive_now = DRV_LEFT;
            last_turn = LAST_LEFT;
        end else if (fb) begin
            begin_reverse();
        end else begin
            drive_now = DRV_STRAIGHT;
            last_turn = LAST_NONE;
        end
        act.drive  = drive_now;
        act.bridge = bridge_pattern(drive_now);
        act.turn   = last_turn;
        return act;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("mismatch at result %0d: %s expected %0d got %0d",
                 results_seen, what, want, got);
        error_count++;
    endtask

    // input driver: holds each transaction until it is taken
    always @(negedge i_clk) begin : tick_driver
        t_tick next_tick;
        if (!i_in_valid || tick_taken) begin
            tick_taken = 1'b0;
            if (pending_ticks.size() != 0 &&
                (quiet_stretch || $urandom_range(99, 0) >= 12)) begin
                next_tick = pending_ticks.pop_front();
                i_in_valid    <= 1'b1;
                i_left_range  <= next_tick.left_r;
                i_right_range <= next_tick.right_r;
                i_front_range <= next_tick.front_r;
                i_back_range  <= next_tick.back_r;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output side back-pressure
    always @(negedge i_clk) begin : result_sink
        i_out_ready <= !hold_off && (quiet_stretch || $urandom_range(99, 0) >= 12);
    end

    // one long receiver stall once requested
    initial begin : long_hold
        wait (hold_req);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // monitor: check results, then predict newly accepted ticks
    always @(posedge i_clk) begin : action_monitor
        t_action want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_actions.size() == 0) begin
                    report_mismatch("result with no tick pending, drive_mode", -1,
                                    o_drive_mode);
                end else begin
                    want = expected_actions.pop_front();
                    if (o_drive_mode !== want.drive)
                        report_mismatch("drive_mode", want.drive, o_drive_mode);
                    if (o_bridge_bits !== want.bridge)
                        report_mismatch("bridge_bits", want.bridge, o_bridge_bits);
                    if (o_turn_memory !== want.turn)
                        report_mismatch("turn_memory", want.turn, o_turn_memory);
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_actions.push_back(predict_action(i_left_range, i_right_range,
                                                          i_front_range, i_back_range));
                tick_taken = 1'b1;
            end
        end
    end

    // watchdog on cycles without any transaction
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAIL obstacle_avoidance_controller_core");
        $finish;
    end

    function automatic void queue_tick(input logic [7:0] left_r, right_r, front_r, back_r);
        pending_ticks.push_back('{left_r, right_r, front_r, back_r});
        ticks_queued++;
    endfunction

    // reading on either side of a threshold, often right at the boundary
    function automatic logic [7:0] pick_reading(input logic [7:0] thr, input bit blocked);
        if (blocked && thr != 8'hFF)
            return ($urandom_range(3, 0) == 0) ? thr + 8'd1
                                               : 8'($urandom_range(255, thr + 1));
        return ($urandom_range(3, 0) == 0) ? thr : 8'($urandom_range(thr, 0));
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_OBSTACLE_THRESHOLD: thr_obstacle = val;
            CFG_REAR_THRESHOLD:     thr_rear     = val;
            CFG_REVERSE_TICKS:      rev_load     = val;
            CFG_TURN_START:         turn_below   = val;
            CFG_ESCAPE_TICKS:       escape_load  = val;
            CFG_OSCILLATION_LIMIT:  swing_limit  = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_config(input logic [7:0] obstacle, rear, rev, turn, esc, osc);
        write_reg(CFG_OBSTACLE_THRESHOLD, obstacle);
        write_reg(CFG_REAR_THRESHOLD, rear);
        write_reg(CFG_REVERSE_TICKS, rev);
        write_reg(CFG_TURN_START, turn);
        write_reg(CFG_ESCAPE_TICKS, esc);
        write_reg(CFG_OSCILLATION_LIMIT, osc);
    endtask

    task automatic wait_for_results();
        while (results_seen != ticks_queued) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // side obstacles that swap sides, now and then repeating a side
    task automatic alternation_run(input int len, input bit strict);
        repeat (len) begin
            queue_tick(pick_reading(thr_obstacle, left_block_next),
                       pick_reading(thr_obstacle, !left_block_next),
                       pick_reading(thr_obstacle, $urandom_range(1, 0)), 8'($urandom));
            if (strict || $urandom_range(7, 0) != 0)
                left_block_next = !left_block_next;
        end
    endtask

    // mix of driving scenarios with random content plus plain noise
    task automatic queue_random(input int n);
        int start;
        int kind;
        int len;
        bit both;
        start = ticks_queued;
        while (ticks_queued - start < n) begin
            kind = $urandom_range(99, 0);
            if (kind < 20) begin
                queue_tick(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end else if (kind < 50) begin
                alternation_run($urandom_range((swing_limit > 8'd20) ? 23 : swing_limit + 3, 2),
                                1'b0);
            end else if (kind < 72) begin
                // blocked ahead, then a reverse with the rear sometimes blocked
                both = $urandom_range(1, 0);
                queue_tick(pick_reading(thr_obstacle, both), pick_reading(thr_obstacle, both),
                           pick_reading(thr_obstacle, 1'b1), 8'($urandom));
                len = $urandom_range((rev_load > 8'd16) ? 16 : rev_load + 2, 1);
                repeat (len)
                    queue_tick(8'($urandom), 8'($urandom), 8'($urandom),
                               pick_reading(thr_rear, $urandom_range(4, 0) == 0));
            end else if (kind < 86) begin
                repeat ($urandom_range(4, 1))
                    queue_tick(pick_reading(thr_obstacle, 1'b0),
                               pick_reading(thr_obstacle, 1'b0),
                               pick_reading(thr_obstacle, 1'b0), 8'($urandom));
            end else begin
                queue_tick(pick_reading(thr_obstacle, $urandom_range(1, 0)),
                           pick_reading(thr_obstacle, $urandom_range(1, 0)),
                           pick_reading(thr_obstacle, $urandom_range(1, 0)), 8'($urandom));
            end
        end
    endtask

    initial begin : stimulus
        logic [7:0] rev;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_left_range  = 8'd0;
        i_right_range = 8'd0;
        i_front_range = 8'd0;
        i_back_range  = 8'd0;
        i_out_ready   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_OBSTACLE_THRESHOLD;
        i_cfg_data    = 8'd0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset configuration: all decisions but the escape, and the boundaries
        queue_tick(8'd0, 8'd0, 8'd0, 8'd0);
        queue_tick(8'd76, 8'd0, 8'd0, 8'd0);
        queue_tick(8'd0, 8'd76, 8'd0, 8'd0);
        queue_tick(8'd75, 8'd75, 8'd75, 8'd255);
        queue_tick(8'd255, 8'd0, 8'd255, 8'd0);
        queue_tick(8'd0, 8'd255, 8'd255, 8'd0);
        queue_tick(8'd0, 8'd0, 8'd76, 8'd0);
        queue_tick(8'd255, 8'd255, 8'd255, 8'd111);
        queue_tick(8'd0, 8'd0, 8'd0, 8'd110);
        wait_for_results();

        // directed, short counters: floored reload, instant escape, one-tick reverse
        load_config(8'd100, 8'd0, 8'd1, 8'd1, 8'd2, 8'd0);
        queue_tick(8'd0, 8'd0, 8'd0, 8'd255);
        queue_tick(8'd0, 8'd0, 8'd0, 8'd0);
        queue_tick(8'd101, 8'd0, 8'd0, 8'd0);
        queue_tick(8'd0, 8'd101, 8'd0, 8'd0);
        queue_tick(8'd255, 8'd255, 8'd255, 8'd255);
        queue_tick(8'd0, 8'd0, 8'd0, 8'd0);
        queue_tick(8'd255, 8'd255, 8'd255, 8'd0);
        queue_tick(8'd0, 8'd0, 8'd0, 8'd0);
        queue_tick(8'd100, 8'd100, 8'd100, 8'd0);
        queue_tick(8'd255, 8'd255, 8'd255, 8'd255);
        queue_tick(8'd0, 8'd0, 8'd0, 8'd1);
        wait_for_results();

        // lowest and highest settings
        load_config(8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 8'd0);
        queue_random(30);
        wait_for_results();
        load_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        queue_random(20);
        wait_for_results();

        // long alternation with no escape load so the count wraps past 255
        load_config(8'($urandom_range(200, 40)), 8'($urandom), 8'd3, 8'd2, 8'd0, 8'd5);
        alternation_run(258, 1'b1);
        wait_for_results();
        // count restarted from the wrap, escape only once it passes the limit again
        write_reg(CFG_ESCAPE_TICKS, 8'd4);
        alternation_run(12, 1'b1);
        queue_random(28);
        wait_for_results();

        // reset values, no idling on either side
        quiet_stretch = 1'b1;
        load_config(RST_OBSTACLE_THRESHOLD, RST_REAR_THRESHOLD, RST_REVERSE_TICKS,
                    RST_TURN_START, RST_ESCAPE_TICKS, RST_OSCILLATION_LIMIT);
        queue_random(30);
        wait_for_results();
        quiet_stretch = 1'b0;

        // random settings with short manoeuvres, one with a long output stall
        for (int p = 0; p < 3; p++) begin
            rev = 8'($urandom_range(24, 1));
            load_config(8'($urandom_range(220, 20)), 8'($urandom), rev,
                        8'($urandom_range(rev + 2, 1)), 8'($urandom_range(12, 0)),
                        8'($urandom_range(8, 0)));
            queue_random(35);
            if (p == 1)
                hold_req = 1'b1;
            wait_for_results();
        end

        repeat (4) @(negedge i_clk);
        if (expected_actions.size() != 0)
            report_mismatch("results still outstanding", 0, expected_actions.size());
        if (error_count == 0)
            $display("PASS obstacle_avoidance_controller_core");
        else
            $display("FAIL obstacle_avoidance_controller_core");
        $finish;
    end

endmodule
